### rtl/xor_sprite_framebuffer_unit_assert.svh
// Assertion macros for the sprite framebuffer RTL.
`ifndef XOR_SPRITE_FRAMEBUFFER_UNIT_ASSERT_SVH
`define XOR_SPRITE_FRAMEBUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define XSFB_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("xsfb: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define XSFB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("xsfb: next-cycle check failed");

`endif

### rtl/xsfb_pkg.sv
// Types, constants and codes for the sprite framebuffer.
`timescale 1ns / 1ps

package xsfb_pkg;

    localparam int SCREEN_ROWS = 32;
    localparam int ROW_BYTES   = 8;
    localparam int ROW_PIX     = ROW_BYTES * 8;
    localparam int STORE_BYTES = SCREEN_ROWS * ROW_BYTES;
    localparam int ROW_W       = $clog2(SCREEN_ROWS);
    localparam int COL_W       = $clog2(ROW_BYTES);
    localparam int XM_W        = $clog2(ROW_PIX);

    typedef enum logic [1:0] {
        KIND_DRAW  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [3:0] sprite_row;
        logic [7:0] sprite_byte;
        logic       last_byte;
        logic [7:0] read_addr;
    } in_item_t;

    typedef struct packed {
        logic       collision;
        logic       sprite_done;
        logic [7:0] read_data;
    } out_item_t;

    typedef struct packed {
        logic [ROW_PIX-1:0] new_row;
        logic               hit;
        logic [7:0]         rd_byte;
    } alu_res_t;

endpackage

### rtl/xsfb_ram.sv
// Generic simple dual-port RAM with registered, read-first output.
`timescale 1ns / 1ps

module xsfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/xsfb_row_alu.sv
// Row datapath: sprite XOR into one framebuffer row, collision and byte read.
`timescale 1ns / 1ps

module xsfb_row_alu (
    input  logic [xsfb_pkg::ROW_PIX-1:0] cur_row,
    input  xsfb_pkg::in_item_t           item,
    input  logic                         in_range,
    output xsfb_pkg::alu_res_t           res
);

    localparam int ROW_PIX = xsfb_pkg::ROW_PIX;
    localparam int COL_W   = xsfb_pkg::COL_W;
    localparam int XM_W    = xsfb_pkg::XM_W;

    logic [ROW_PIX-1:0]   ext;
    logic [2*ROW_PIX-1:0] dbl;
    logic [2*ROW_PIX-1:0] rot;
    logic [ROW_PIX-1:0]   mask;
    logic [ROW_PIX-1:0]   upd;
    logic [XM_W-1:0]      xm;
    logic [COL_W-1:0]     col;
    logic [COL_W-1:0]     col_inv;
    logic [ROW_PIX-1:0]   byte_shift;
    logic                 is_draw;
    logic                 rd_ok;

    // Pixel p of the row sits at bit ROW_PIX-1-p, so the sprite is a rotate right.
    assign xm      = item.pos_x[XM_W-1:0];
    assign ext     = {item.sprite_byte, {(ROW_PIX-8){1'b0}}};
    assign dbl     = {ext, ext};
    assign rot     = dbl >> xm;
    assign is_draw = (item.kind == xsfb_pkg::KIND_DRAW);
    assign mask    = (is_draw && in_range) ? rot[ROW_PIX-1:0] : '0;
    assign upd     = cur_row ^ mask;

    assign col        = item.read_addr[COL_W-1:0];
    assign col_inv    = COL_W'(xsfb_pkg::ROW_BYTES - 1) - col;
    assign byte_shift = cur_row >> {col_inv, 3'b000};
    assign rd_ok      = ({1'b0, item.read_addr} < 9'(xsfb_pkg::STORE_BYTES)) &&
                        (item.kind == xsfb_pkg::KIND_READ);

    always_comb begin
        res.new_row = upd;
        res.hit     = |(cur_row & ~upd);
        res.rd_byte = rd_ok ? byte_shift[7:0] : 8'h00;
    end

endmodule

### rtl/xor_sprite_framebuffer_unit.sv
// Top level of the sprite framebuffer: row RAM, forwarding and handshakes.
// Pipeline: an accepted item is registered in stage 1 while its row is read from RAM,
// then loaded into the result register that drives m_ once m_ is free to take it.
// Throughput: one item per cycle while m_ready keeps up; the row RAM is read on
// acceptance and written as the item leaves stage 1, with a read of the row being written forwarded.
// Reset (synchronous, aresetn low) clears row valids, accumulator and stage valids.
`timescale 1ns / 1ps
`include "xor_sprite_framebuffer_unit_assert.svh"

module xor_sprite_framebuffer_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  xsfb_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output xsfb_pkg::out_item_t m_item
);

    localparam int ROW_PIX     = xsfb_pkg::ROW_PIX;
    localparam int ROW_W       = xsfb_pkg::ROW_W;
    localparam int COL_W       = xsfb_pkg::COL_W;
    localparam int SCREEN_ROWS = xsfb_pkg::SCREEN_ROWS;

    logic                   s_accept;
    logic                   s1_fire;
    logic [8:0]             draw_sum;
    logic [ROW_W-1:0]       in_row;
    logic                   in_range;
    logic                   s1_is_draw;
    logic                   s1_is_clear;
    logic                   wr_en;
    logic                   fwd_next;
    logic                   zero_next;
    logic [ROW_PIX-1:0]     ram_q;
    logic [ROW_PIX-1:0]     cur_row;
    xsfb_pkg::alu_res_t     alu_res;

    logic                   s1_valid_reg;
    xsfb_pkg::in_item_t     s1_item_reg;
    logic [ROW_W-1:0]       s1_row_reg;
    logic                   s1_in_range_reg;
    logic                   rd_fwd_reg;
    logic                   rd_zero_reg;
    logic [ROW_PIX-1:0]     fwd_data_reg;
    logic [SCREEN_ROWS-1:0] row_valid_reg;
    logic [SCREEN_ROWS-1:0] row_valid_next;
    logic                   collision_acc_reg;
    logic                   collision_acc_next;
    logic                   m_valid_reg;
    xsfb_pkg::out_item_t    m_item_reg;
    xsfb_pkg::out_item_t    m_item_next;

    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_accept = s_valid && s_ready;

    assign draw_sum = {1'b0, s_item.pos_y} + 9'(s_item.sprite_row);
    assign in_range = (draw_sum < 9'(SCREEN_ROWS));
    assign in_row   = (s_item.kind == xsfb_pkg::KIND_READ) ?
                      s_item.read_addr[COL_W +: ROW_W] : draw_sum[ROW_W-1:0];

    assign s1_is_draw  = (s1_item_reg.kind == xsfb_pkg::KIND_DRAW);
    assign s1_is_clear = (s1_item_reg.kind == xsfb_pkg::KIND_CLEAR);
    assign wr_en       = s1_fire && s1_is_draw && s1_in_range_reg;

    // The RAM returns the old row when it is written in the same cycle: forward.
    assign fwd_next  = wr_en && (s1_row_reg == in_row);
    assign zero_next = (s1_fire && s1_is_clear) || !row_valid_reg[in_row];

    assign cur_row = rd_fwd_reg ? fwd_data_reg : (rd_zero_reg ? '0 : ram_q);

    xsfb_ram #(
        .WIDTH(ROW_PIX),
        .DEPTH(SCREEN_ROWS)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(s1_row_reg),
        .wr_data(alu_res.new_row),
        .rd_en  (s_accept),
        .rd_addr(in_row),
        .rd_data(ram_q)
    );

    xsfb_row_alu u_alu (
        .cur_row (cur_row),
        .item    (s1_item_reg),
        .in_range(s1_in_range_reg),
        .res     (alu_res)
    );

    always_comb begin
        row_valid_next     = row_valid_reg;
        collision_acc_next = collision_acc_reg;
        m_item_next        = '0;
        if (s1_is_clear) begin
            row_valid_next = '0;
        end else if (wr_en) begin
            row_valid_next[s1_row_reg] = 1'b1;
        end
        if (s1_is_draw) begin
            m_item_next.collision   = collision_acc_reg | alu_res.hit;
            m_item_next.sprite_done = s1_item_reg.last_byte;
            // Drop the accumulated collision after the last byte of a sprite.
            collision_acc_next = s1_item_reg.last_byte ? 1'b0 :
                                 (collision_acc_reg | alu_res.hit);
        end
        m_item_next.read_data = alu_res.rd_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            row_valid_reg     <= '0;
            collision_acc_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                m_valid_reg       <= 1'b1;
                row_valid_reg     <= row_valid_next;
                collision_acc_reg <= collision_acc_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg     <= s_item;
            s1_row_reg      <= in_row;
            s1_in_range_reg <= in_range;
            rd_fwd_reg      <= fwd_next;
            rd_zero_reg     <= zero_next;
            fwd_data_reg    <= alu_res.new_row;
        end
        if (s1_fire) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `XSFB_ASSERT_NOW(a_hold_when_stalled, aclk, aresetn,
        s1_valid_reg && m_valid_reg && !m_ready, !s_ready)
    `XSFB_ASSERT_NEXT(a_no_flags_off_draw, aclk, aresetn,
        s1_fire && !s1_is_draw, !m_item.collision && !m_item.sprite_done)
    `XSFB_ASSERT_NEXT(a_clear_drops_rows, aclk, aresetn,
        s1_fire && s1_is_clear, row_valid_reg == '0)
    `XSFB_ASSERT_NEXT(a_last_byte_resets_acc, aclk, aresetn,
        s1_fire && s1_is_draw && s1_item_reg.last_byte, !collision_acc_reg)

endmodule

### tb/testbench.sv
// Self-checking testbench for the sprite framebuffer: directed and random draws, clears, reads and unused kinds.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        xsfb_pkg::in_item_t item;
        int                 idle_after;
    } stim_entry_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    xsfb_pkg::in_item_t  s_item = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    xsfb_pkg::out_item_t m_item;

    stim_entry_t         pending_items[$];
    xsfb_pkg::out_item_t expected_results[$];

    // Shadow copy of the pixel store and the sprite collision flag.
    logic [7:0] shadow_frame [0:xsfb_pkg::STORE_BYTES-1];
    logic       shadow_hit;

    int errors = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int tx_wait = 0;
    bit tx_calm = 1'b0;
    int tx_calm_left = 0;
    int rx_gap = 0;
    int rx_phase = 0;
    bit rx_calm = 1'b0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    xor_sprite_framebuffer_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // XOR one sprite byte into the shadow store; return the on-to-off flag.
    function automatic logic xor_pixels(int addr, logic [7:0] bits);
        logic [7:0] old;
        logic [7:0] upd;
        old = shadow_frame[addr];
        upd = old ^ bits;
        shadow_frame[addr] = upd;
        return |(old & ~upd);
    endfunction

    task automatic frame_predict(input xsfb_pkg::in_item_t it,
                                 output xsfb_pkg::out_item_t res);
        int          xm;
        int          row;
        int          col;
        int          shift;
        int          base;
        logic [15:0] spread;
        logic        hit;
        res = '0;
        case (it.kind)
            xsfb_pkg::KIND_DRAW: begin
                xm = it.pos_x % xsfb_pkg::ROW_PIX;
                row = int'(it.pos_y) + int'(it.sprite_row);
                if (row < xsfb_pkg::SCREEN_ROWS) begin
                    col = xm / 8;
                    shift = xm % 8;
                    base = row * xsfb_pkg::ROW_BYTES;
                    spread = {it.sprite_byte, 8'h00} >> shift;
                    hit = xor_pixels(base + col, spread[15:8]);
                    // spill into the next byte, wrapping to the row start
                    if (shift != 0)
                        hit |= xor_pixels((col + 1 >= xsfb_pkg::ROW_BYTES) ? base
                                                                         : base + col + 1,
                                          spread[7:0]);
                    shadow_hit |= hit;
                end
                res.collision = shadow_hit;
                res.sprite_done = it.last_byte;
                if (it.last_byte)
                    shadow_hit = 1'b0;
            end
            xsfb_pkg::KIND_CLEAR: begin
                for (int i = 0; i < xsfb_pkg::STORE_BYTES; i++)
                    shadow_frame[i] = 8'h00;
            end
            xsfb_pkg::KIND_READ: begin
                if (int'(it.read_addr) < xsfb_pkg::STORE_BYTES)
                    res.read_data = shadow_frame[it.read_addr];
            end
            default: ;
        endcase
    endtask

    function automatic xsfb_pkg::in_item_t random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(xsfb_pkg::in_item_t)-1:0];
    endfunction

    function automatic xsfb_pkg::in_item_t make_item(logic [1:0] kind, logic [7:0] x,
                                                     logic [7:0] y, logic [3:0] srow,
                                                     logic [7:0] pix, logic last,
                                                     logic [7:0] addr);
        xsfb_pkg::in_item_t it;
        it.kind = kind;
        it.pos_x = x;
        it.pos_y = y;
        it.sprite_row = srow;
        it.sprite_byte = pix;
        it.last_byte = last;
        it.read_addr = addr;
        return it;
    endfunction

    task automatic queue_item(input xsfb_pkg::in_item_t it);
        stim_entry_t e;
        int          r;
        if (tx_calm_left == 0) begin
            tx_calm = ($urandom_range(0, 2) == 0);
            tx_calm_left = $urandom_range(20, 120);
        end
        tx_calm_left--;
        r = $urandom_range(0, 99);
        e.item = it;
        if (tx_calm || r < 60)
            e.idle_after = 0;
        else if (r < 90)
            e.idle_after = $urandom_range(1, 3);
        else
            e.idle_after = $urandom_range(8, 30);
        pending_items.push_back(e);
    endtask

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 1);
        else if (r < 95)
            return $urandom_range(2, 5);
        return $urandom_range(10, 40);
    endfunction

    // Driver: present queued items, idling between them as each entry asks.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait <= 0;
        end else if (!s_valid || s_ready) begin
            if (tx_wait != 0) begin
                s_valid <= 1'b0;
                tx_wait <= tx_wait - 1;
            end else if (pending_items.size() != 0) begin
                s_item <= pending_items[0].item;
                tx_wait <= pending_items[0].idle_after;
                void'(pending_items.pop_front());
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_phase == 0) begin
                rx_phase <= $urandom_range(30, 200);
                rx_calm <= ($urandom_range(0, 2) == 0);
            end else begin
                rx_phase <= rx_phase - 1;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                m_ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else if (rx_gap != 0) begin
                m_ready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end else if (rx_calm || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_gap <= stall_len();
            end
        end
    end

    // Monitor: predict on input acceptance, then check any accepted result.
    always @(posedge aclk) begin
        xsfb_pkg::out_item_t want;
        if (!aresetn) begin
            for (int i = 0; i < xsfb_pkg::STORE_BYTES; i++)
                shadow_frame[i] = 8'h00;
            shadow_hit = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                frame_predict(s_item, want);
                expected_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, m_item);
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.collision !== want.collision) begin
                        errors++;
                        $display("%0t: collision expected %0b actual %0b",
                                 $time, want.collision, m_item.collision);
                    end
                    if (m_item.sprite_done !== want.sprite_done) begin
                        errors++;
                        $display("%0t: sprite_done expected %0b actual %0b",
                                 $time, want.sprite_done, m_item.sprite_done);
                    end
                    if (m_item.read_data !== want.read_data) begin
                        errors++;
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, m_item.read_data);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        xsfb_pkg::in_item_t it;
        int                 r;
        int                 n;
        int                 x;
        int                 y;
        int                 last_row;
        bit                 broken;

        // Directed: blank store, overlap collision, off-screen rows, column wrap.
        queue_item(make_item(xsfb_pkg::KIND_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 8'd0));
        queue_item(make_item(xsfb_pkg::KIND_READ, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 8'd255));
        queue_item(make_item(xsfb_pkg::KIND_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF, 1'b0, 8'h00));
        queue_item(make_item(xsfb_pkg::KIND_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF, 1'b0, 8'hFF));
        queue_item(make_item(xsfb_pkg::KIND_DRAW, 8'd0, 8'd40, 4'd0, 8'hFF, 1'b1, 8'h00));
        queue_item(make_item(xsfb_pkg::KIND_DRAW, 8'd0, 8'd0, 4'd0, 8'h81, 1'b1, 8'h00));
        queue_item(make_item(xsfb_pkg::KIND_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 8'd0));
        queue_item(make_item(xsfb_pkg::KIND_DRAW, 8'd5, 8'd1, 4'd0, 8'hFF, 1'b0, 8'h00));
        queue_item(make_item(xsfb_pkg::KIND_DRAW, 8'd63, 8'd1, 4'd1, 8'hFF, 1'b1, 8'h00));
        queue_item(make_item(xsfb_pkg::KIND_DRAW, 8'd255, 8'd31, 4'd0, 8'hA5, 1'b0, 8'h00));
        queue_item(make_item(xsfb_pkg::KIND_DRAW, 8'd64, 8'd30, 4'd1, 8'h5A, 1'b1, 8'h00));
        queue_item(make_item(xsfb_pkg::KIND_DRAW, 8'd7, 8'd255, 4'd15, 8'hFF, 1'b1, 8'hFF));
        queue_item(make_item(xsfb_pkg::KIND_DRAW, 8'd0, 8'd0, 4'd15, 8'hFF, 1'b1, 8'h00));
        queue_item(make_item(xsfb_pkg::KIND_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 8'd8));
        queue_item(make_item(xsfb_pkg::KIND_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 8'd15));
        queue_item(make_item(xsfb_pkg::KIND_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 8'd16));
        queue_item(make_item(xsfb_pkg::KIND_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 8'd23));
        queue_item(make_item(xsfb_pkg::KIND_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 8'd248));
        queue_item(make_item(xsfb_pkg::KIND_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 8'd255));
        queue_item(make_item(KIND_UNUSED, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 8'hFF));
        queue_item(make_item(xsfb_pkg::KIND_CLEAR, 8'hAA, 8'h55, 4'hA, 8'h3C, 1'b1, 8'h77));
        queue_item(make_item(xsfb_pkg::KIND_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 8'd0));
        queue_item(make_item(xsfb_pkg::KIND_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 8'd255));
        queue_item(make_item(xsfb_pkg::KIND_DRAW, 8'd200, 8'd17, 4'd3, 8'h00, 1'b1, 8'h00));

        // Random: mostly whole sprites, reads near recent rows, some noise.
        last_row = 0;
        while (pending_items.size() < RANDOM_ITEMS + 24) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                n = $urandom_range(1, 16);
                x = $urandom_range(0, 255);
                y = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 31)
                                                 : $urandom_range(0, 255);
                broken = ($urandom_range(0, 9) == 0);
                last_row = y;
                for (int i = 0; i < n; i++) begin
                    it = random_item();
                    it.kind = xsfb_pkg::KIND_DRAW;
                    it.pos_x = 8'(x);
                    it.pos_y = 8'(y);
                    it.sprite_row = 4'(i);
                    it.last_byte = (i == n - 1) && !broken;
                    queue_item(it);
                end
            end else if (r < 85) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    it = random_item();
                    it.kind = xsfb_pkg::KIND_READ;
                    if ($urandom_range(0, 3) != 0)
                        it.read_addr = 8'(((last_row + $urandom_range(0, 15))
                                           % xsfb_pkg::SCREEN_ROWS) * xsfb_pkg::ROW_BYTES
                                          + $urandom_range(0, xsfb_pkg::ROW_BYTES - 1));
                    queue_item(it);
                end
            end else if (r < 88) begin
                it = random_item();
                it.kind = xsfb_pkg::KIND_CLEAR;
                queue_item(it);
            end else if (r < 92) begin
                it = random_item();
                it.kind = KIND_UNUSED;
                queue_item(it);
            end else begin
                queue_item(random_item());
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
